// File: rtl/light_sweep_pixel_brighten_defines.svh
// ---------------------------------------------------------------------------
// Light sweep brightener assertion macros
// Concurrent checks on clk, disabled while rst is high; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef LIGHT_SWEEP_PIXEL_BRIGHTEN_DEFINES_SVH
`define LIGHT_SWEEP_PIXEL_BRIGHTEN_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LSB_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("light sweep check failed");
// next-cycle implication
`define LSB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("light sweep check failed");
`else
`define LSB_ASSERT_IMPL(name, ante, cons)
`define LSB_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// File: rtl/lsb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsb_pkg
// Shared types, register codes and fixed-point constants of the light sweep
// pixel brightener.
// ---------------------------------------------------------------------------
package lsb_pkg;

  localparam int COORD_BITS_DEF = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X       = 3'd0,
    REG_CENTER_Y       = 3'd1,
    REG_DIR_COS        = 3'd2,
    REG_DIR_SIN        = 3'd3,
    REG_SWEEP_WIDTH    = 3'd4,
    REG_INV_HALF_WIDTH = 3'd5,
    REG_SWEEP_GAIN     = 3'd6,
    REG_EDGE_GAIN      = 3'd7
  } cfg_idx_t;

  localparam int WIDTH_W = 13;
  localparam int SGAIN_W = 10;
  localparam int EGAIN_W = 9;
  localparam int INV5_W  = 19;

  localparam logic [15:0]        CENTER_X_RST       = 16'd15360;
  localparam logic [15:0]        CENTER_Y_RST       = 16'd8640;
  localparam logic signed [15:0] DIR_COS_RST        = 16'sd14189;
  localparam logic signed [15:0] DIR_SIN_RST        = -16'sd8192;
  localparam logic [WIDTH_W-1:0] SWEEP_WIDTH_RST    = 13'd1600;
  localparam logic [15:0]        INV_HALF_WIDTH_RST = 16'd1311;
  localparam logic [INV5_W-1:0]  INV5_RST           = INV5_W'(1311 * 5);
  localparam logic [SGAIN_W-1:0] SWEEP_GAIN_RST     = 10'd128;
  localparam logic [EGAIN_W-1:0] EDGE_GAIN_RST      = 9'd128;

  // distances inside either zone fit these bits (half width < 2^26)
  localparam int ZONE_W     = 26;
  localparam int HALF_SHIFT = 13;
  localparam int EDGE_SHIFT = 14;
  // ramp = (2^34 - d*inv) >> 18, at most 2^16
  localparam int ONE_SHIFT  = 34;
  localparam int RAMP_LSB   = 18;
  localparam int RAMP_W     = 17;
  localparam int GAIN_SHIFT = 8;
  localparam int WC_W       = 19;
  localparam int WE_W       = 18;
  localparam int AMOUNT_W   = 20;
  localparam logic [AMOUNT_W-1:0] AMOUNT_MIN = 20'd655;
  localparam int ADD_W      = 12;

  typedef struct packed {
    logic [15:0]         center_x;
    logic [15:0]         center_y;
    logic signed [15:0]  dir_cos;
    logic signed [15:0]  dir_sin;
    logic [WIDTH_W-1:0]  sweep_width;
    logic [15:0]         inv_half_width;
    logic [INV5_W-1:0]   inv5;
    logic [SGAIN_W-1:0]  sweep_gain;
    logic [EGAIN_W-1:0]  edge_gain;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [ZONE_W-1:0] sweep;
    logic [ZONE_W-1:0] edge_dist;
    logic              in_center;
    logic              in_edge;
    rgb_t              rgb;
  } geo_t;

  typedef struct packed {
    logic [ADD_W-1:0] add;
    rgb_t             rgb;
  } amt_t;

endpackage

// File: rtl/lsb_pix_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsb_pix_in_if
// Pixel input channel: position and RGB bytes with valid/ready.
// ---------------------------------------------------------------------------
interface lsb_pix_in_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [7:0]            red_in;
  logic [7:0]            green_in;
  logic [7:0]            blue_in;

  modport source (output valid, pixel_x, pixel_y, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, red_in, green_in, blue_in,
                  output ready);
endinterface

// File: rtl/lsb_pix_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsb_pix_out_if
// Pixel output channel: brightened RGB bytes with valid/ready.
// ---------------------------------------------------------------------------
interface lsb_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// File: rtl/lsb_cfg_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsb_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ---------------------------------------------------------------------------
interface lsb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/light_sweep_pixel_brighten.sv
`timescale 1ns / 1ps
// Structure: 5 distance stages, 4 amount stages and 1 output register lie between
//   an accepted pixel and its result on pixel_out.
// Throughput: one pixel per clock while pixel_out is ready; every stage stalls on its own,
//   so bubbles close up and the input stays ready while any stage is empty.
// Reset (rst, synchronous): empties the pipeline and loads the register defaults.
// ---------------------------------------------------------------------------
// light_sweep_pixel_brighten
// Brightens pixels near a configurable sweep line: centre ramp plus edge ramp.
// ---------------------------------------------------------------------------
`include "light_sweep_pixel_brighten_defines.svh"

module light_sweep_pixel_brighten #(
  parameter int COORD_BITS = lsb_pkg::COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  lsb_cfg_if.sink       cfg,
  lsb_pix_in_if.sink    pixel_in,
  lsb_pix_out_if.source pixel_out
);
  import lsb_pkg::*;

  cfg_t cfg_q;
  logic geo_valid, geo_ready;
  geo_t geo_data;
  logic amt_valid, amt_ready;
  amt_t amt_data;

  lsb_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  lsb_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_q),
    .pix_in    (pixel_in),
    .out_valid (geo_valid),
    .out_ready (geo_ready),
    .out_data  (geo_data)
  );

  lsb_ramp u_ramp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_q),
    .in_valid  (geo_valid),
    .in_ready  (geo_ready),
    .in_data   (geo_data),
    .out_valid (amt_valid),
    .out_ready (amt_ready),
    .out_data  (amt_data)
  );

  lsb_blend u_blend (
    .clk      (clk),
    .rst      (rst),
    .in_valid (amt_valid),
    .in_ready (amt_ready),
    .in_data  (amt_data),
    .pix_out  (pixel_out)
  );

  // an empty output register lets every stage advance
  `LSB_ASSERT_IMPL(a_ready_when_out_free, !pixel_out.valid, pixel_in.ready)
  // above the threshold the increment is at least two
  `LSB_ASSERT_IMPL(a_add_threshold, amt_valid,
                   amt_data.add == '0 || amt_data.add >= ADD_W'(2))
  `LSB_ASSERT_NEXT(a_gain_write,
                   cfg.valid && cfg.ready && cfg.index == REG_SWEEP_GAIN,
                   cfg_q.sweep_gain == $past(cfg.data[SGAIN_W-1:0]))
  `LSB_ASSERT_IMPL(a_reset_values, $past(rst),
                   cfg_q.center_x == CENTER_X_RST && cfg_q.sweep_width == SWEEP_WIDTH_RST)

endmodule

// File: rtl/lsb_cfg_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsb_cfg_regs
// Configuration register file; also keeps five times the half-width
// reciprocal for the edge ramp.
// ---------------------------------------------------------------------------
module lsb_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  lsb_cfg_if.sink       cfg,
  output lsb_pkg::cfg_t cfg_q
);
  import lsb_pkg::*;

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.center_x       <= CENTER_X_RST;
      cfg_q.center_y       <= CENTER_Y_RST;
      cfg_q.dir_cos        <= DIR_COS_RST;
      cfg_q.dir_sin        <= DIR_SIN_RST;
      cfg_q.sweep_width    <= SWEEP_WIDTH_RST;
      cfg_q.inv_half_width <= INV_HALF_WIDTH_RST;
      cfg_q.inv5           <= INV5_RST;
      cfg_q.sweep_gain     <= SWEEP_GAIN_RST;
      cfg_q.edge_gain      <= EDGE_GAIN_RST;
    end else if (wr) begin
      case (cfg_idx_t'(cfg.index))
        REG_CENTER_X:       cfg_q.center_x    <= cfg.data;
        REG_CENTER_Y:       cfg_q.center_y    <= cfg.data;
        REG_DIR_COS:        cfg_q.dir_cos     <= signed'(cfg.data);
        REG_DIR_SIN:        cfg_q.dir_sin     <= signed'(cfg.data);
        REG_SWEEP_WIDTH:    cfg_q.sweep_width <= cfg.data[WIDTH_W-1:0];
        REG_INV_HALF_WIDTH: begin
          cfg_q.inv_half_width <= cfg.data;
          cfg_q.inv5           <= INV5_W'({cfg.data, 2'b00}) + INV5_W'(cfg.data);
        end
        REG_SWEEP_GAIN:     cfg_q.sweep_gain  <= cfg.data[SGAIN_W-1:0];
        REG_EDGE_GAIN:      cfg_q.edge_gain   <= cfg.data[EGAIN_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/lsb_geom.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsb_geom
// Five-stage distance pipeline: offsets, projections, sum, magnitude, then
// band zone tests against the half width.
// ---------------------------------------------------------------------------
module lsb_geom #(
  parameter int COORD_BITS = lsb_pkg::COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  lsb_pkg::cfg_t cfg,
  lsb_pix_in_if.sink    pix_in,
  output logic          out_valid,
  input  logic          out_ready,
  output lsb_pkg::geo_t out_data
);
  import lsb_pkg::*;

  localparam int X_W   = COORD_BITS + 4;
  localparam int DW    = ((X_W > 16) ? X_W : 16) + 1;
  localparam int PW    = DW + 16;
  localparam int SW    = PW + 1;
  localparam int E10_W = SW + 4;
  localparam int NST   = 5;

  logic [NST-1:0] v;
  logic [NST-1:0] adv;

  logic signed [DW-1:0] xs, ys, cxs, cys;
  logic signed [DW-1:0] dx, dy;
  logic signed [15:0]   cos_s, sin_s;
  logic signed [PW-1:0] px, py;
  logic signed [SW-1:0] dist_sum;
  logic [SW-1:0]        sweep, sweep_next;
  logic [SW-1:0]        half, edge_d;
  logic [E10_W-1:0]     edge10, edge_lim;
  logic                 in_c;
  rgb_t                 rgb_in, rgb1, rgb2, rgb3, rgb4;

  always_comb begin
    adv[NST-1] = !v[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign pix_in.ready = adv[0];
  assign out_valid    = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= pix_in.valid;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  assign rgb_in = '{red: pix_in.red_in, green: pix_in.green_in, blue: pix_in.blue_in};
  assign xs     = signed'(DW'({pix_in.pixel_x, 4'b0000}));
  assign ys     = signed'(DW'({pix_in.pixel_y, 4'b0000}));
  assign cxs    = signed'(DW'(cfg.center_x));
  assign cys    = signed'(DW'(cfg.center_y));
  assign cos_s  = cfg.dir_cos;
  assign sin_s  = cfg.dir_sin;

  assign sweep_next = dist_sum[SW-1] ? unsigned'(-dist_sum) : unsigned'(dist_sum);

  // zone tests: centre is inside the half width, edge within a tenth of the width
  assign half     = SW'({cfg.sweep_width, {HALF_SHIFT{1'b0}}});
  assign in_c     = sweep < half;
  assign edge_d   = in_c ? half - sweep : sweep - half;
  assign edge10   = (E10_W'(edge_d) << 3) + (E10_W'(edge_d) << 1);
  assign edge_lim = E10_W'({cfg.sweep_width, {EDGE_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx   <= xs - cxs;
      dy   <= ys - cys;
      rgb1 <= rgb_in;
    end
    if (adv[1]) begin
      px   <= dx * cos_s;
      py   <= dy * sin_s;
      rgb2 <= rgb1;
    end
    if (adv[2]) begin
      dist_sum <= SW'(px) + SW'(py);
      rgb3     <= rgb2;
    end
    if (adv[3]) begin
      sweep <= sweep_next;
      rgb4  <= rgb3;
    end
    if (adv[4]) begin
      out_data.sweep     <= sweep[ZONE_W-1:0];
      out_data.edge_dist <= edge_d[ZONE_W-1:0];
      out_data.in_center <= in_c;
      out_data.in_edge   <= edge10 < edge_lim;
      out_data.rgb       <= rgb4;
    end
  end
endmodule

// File: rtl/lsb_ramp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsb_ramp
// Four-stage amount pipeline: reciprocal products, ramps, gains, then the
// threshold and the scaling of the amount to a channel increment.
// ---------------------------------------------------------------------------
module lsb_ramp (
  input  logic          clk,
  input  logic          rst,
  input  lsb_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  lsb_pkg::geo_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lsb_pkg::amt_t out_data
);
  import lsb_pkg::*;

  localparam int PC_W  = ZONE_W + 16;
  localparam int PE_W  = ZONE_W + INV5_W;
  localparam int MC_W  = RAMP_W + SGAIN_W;
  localparam int ME_W  = RAMP_W + EGAIN_W;
  localparam int SC_W  = AMOUNT_W + 8;
  localparam int NST   = 4;
  localparam logic [PC_W-1:0] ONE_C = PC_W'(1) << ONE_SHIFT;
  localparam logic [PE_W-1:0] ONE_E = PE_W'(1) << ONE_SHIFT;

  logic [NST-1:0] v;
  logic [NST-1:0] adv;

  logic [PC_W-1:0]     prod_c, diff_c;
  logic [PE_W-1:0]     prod_e, diff_e;
  logic                zc1, ze1;
  logic [RAMP_W-1:0]   ramp_c, ramp_e;
  logic [MC_W-1:0]     mul_c;
  logic [ME_W-1:0]     mul_e;
  logic [WC_W-1:0]     wc;
  logic [WE_W-1:0]     we;
  logic [AMOUNT_W-1:0] amount;
  logic [SC_W-1:0]     scaled;
  rgb_t                rgb1, rgb2, rgb3;

  always_comb begin
    adv[NST-1] = !v[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  assign diff_c = ONE_C - prod_c;
  assign diff_e = ONE_E - prod_e;
  assign mul_c  = MC_W'(ramp_c) * MC_W'(cfg.sweep_gain);
  assign mul_e  = ME_W'(ramp_e) * ME_W'(cfg.edge_gain);
  assign amount = AMOUNT_W'(wc) + AMOUNT_W'(we);
  // amount * 255 as a shift and subtract
  assign scaled = (SC_W'(amount) << 8) - SC_W'(amount);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prod_c <= PC_W'(in_data.sweep) * PC_W'(cfg.inv_half_width);
      prod_e <= PE_W'(in_data.edge_dist) * PE_W'(cfg.inv5);
      zc1    <= in_data.in_center;
      ze1    <= in_data.in_edge;
      rgb1   <= in_data.rgb;
    end
    if (adv[1]) begin
      // drop a ramp outside its zone or where it would go negative
      ramp_c <= (zc1 && prod_c < ONE_C) ? diff_c[RAMP_LSB +: RAMP_W] : '0;
      ramp_e <= (ze1 && prod_e < ONE_E) ? diff_e[RAMP_LSB +: RAMP_W] : '0;
      rgb2   <= rgb1;
    end
    if (adv[2]) begin
      wc   <= mul_c[GAIN_SHIFT +: WC_W];
      we   <= mul_e[GAIN_SHIFT +: WE_W];
      rgb3 <= rgb2;
    end
    if (adv[3]) begin
      out_data.add <= (amount > AMOUNT_MIN) ? scaled[16 +: ADD_W] : '0;
      out_data.rgb <= rgb3;
    end
  end
endmodule

// File: rtl/lsb_blend.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsb_blend
// Output register: adds the increment to each channel, saturating at 255.
// ---------------------------------------------------------------------------
module lsb_blend (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lsb_pkg::amt_t in_data,
  lsb_pix_out_if.source pix_out
);
  import lsb_pkg::*;

  localparam int SUM_W = ADD_W + 1;

  logic             v;
  logic             adv;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;

  function automatic logic [7:0] sat8(input logic [SUM_W-1:0] s);
    sat8 = (s > SUM_W'(255)) ? 8'hFF : s[7:0];
  endfunction

  assign adv           = !v || pix_out.ready;
  assign in_ready      = adv;
  assign pix_out.valid = v;

  assign sum_r = SUM_W'(in_data.rgb.red)   + SUM_W'(in_data.add);
  assign sum_g = SUM_W'(in_data.rgb.green) + SUM_W'(in_data.add);
  assign sum_b = SUM_W'(in_data.rgb.blue)  + SUM_W'(in_data.add);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (adv) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_out.red_out   <= sat8(sum_r);
      pix_out.green_out <= sat8(sum_g);
      pix_out.blue_out  <= sat8(sum_b);
    end
  end
endmodule

// File: tb/light_sweep_pixel_brighten_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// light_sweep_pixel_brighten_tb
// Streams pixels through the sweep brightener under a series of register
// settings. It predicts each brightened pixel in fixed point at input
// acceptance and compares every output transaction in order, with random
// idling on both channels and one long output hold-off.
// ---------------------------------------------------------------------------
module light_sweep_pixel_brighten_tb;
  import lsb_pkg::*;

  localparam int COORD_BITS = COORD_BITS_DEF;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam real PI        = 3.14159265358979;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    rgb_t                  rgb;
  } pixel_t;

  typedef struct {
    logic [15:0]         center_x;
    logic [15:0]         center_y;
    logic signed [15:0]  dir_cos;
    logic signed [15:0]  dir_sin;
    logic [WIDTH_W-1:0]  sweep_width;
    logic [15:0]         inv_half_width;
    logic [SGAIN_W-1:0]  sweep_gain;
    logic [EGAIN_W-1:0]  edge_gain;
  } band_setting_t;

  typedef struct {
    pixel_t pix;
    rgb_t   rgb;
  } awaited_t;

  logic clk = 1'b0;
  logic rst;

  lsb_cfg_if                              cfg_bus ();
  lsb_pix_in_if #(.COORD_BITS(COORD_BITS)) pix_in_bus ();
  lsb_pix_out_if                          pix_out_bus ();

  light_sweep_pixel_brighten #(.COORD_BITS(COORD_BITS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_bus),
    .pixel_in  (pix_in_bus),
    .pixel_out (pix_out_bus)
  );

  always #2 clk = ~clk;

  band_setting_t band;
  logic [15:0]   reg_words [8];
  pixel_t        pixel_q [$];
  awaited_t      awaited_q [$];
  pixel_t        offered;
  int unsigned   send_gap;
  int unsigned   recv_gap;
  int unsigned   accepted_count;
  int unsigned   mismatches;
  bit            idling_on;
  logic          long_hold;

  // ---- prediction --------------------------------------------------------

  // (1 - d*inv) in Q1.16 with d in Q.18 and inv in Q0.16; clip at zero
  function automatic longint unsigned band_ramp(longint unsigned d, longint unsigned inv);
    longint unsigned prod;
    prod = d * inv;
    if (prod >= (64'd1 << 34))
      return 0;
    return ((64'd1 << 34) - prod) >> 18;
  endfunction

  function automatic logic [7:0] sat_add(logic [7:0] c, longint unsigned inc);
    longint unsigned s;
    s = c + inc;
    return (s > 255) ? 8'hFF : s[7:0];
  endfunction

  function automatic rgb_t brightened_rgb(pixel_t p, band_setting_t b);
    longint          dx, dy, dist_sum;
    longint unsigned sweep, half, edge_dist, amount, inc;
    rgb_t            r;
    dx = longint'(p.x) * 16 - longint'(b.center_x);
    dy = longint'(p.y) * 16 - longint'(b.center_y);
    // Q.4 offsets times Q1.14 direction give distance in Q.18
    dist_sum = dx * longint'(b.dir_cos) + dy * longint'(b.dir_sin);
    sweep = (dist_sum < 0) ? -dist_sum : dist_sum;
    half = longint'(b.sweep_width) << 13;
    edge_dist = (sweep >= half) ? sweep - half : half - sweep;
    amount = 0;
    if (sweep < half)
      amount += (band_ramp(sweep, b.inv_half_width) * b.sweep_gain) >> 8;
    // edge zone is a tenth of the full width either side of the band edge
    if (edge_dist * 10 < (longint'(b.sweep_width) << 14))
      amount += (band_ramp(edge_dist, longint'(b.inv_half_width) * 5) * b.edge_gain) >> 8;
    inc = (amount > 655) ? (amount * 255) >> 16 : 0;
    r.red   = sat_add(p.rgb.red, inc);
    r.green = sat_add(p.rgb.green, inc);
    r.blue  = sat_add(p.rgb.blue, inc);
    return r;
  endfunction

  // ---- stimulus helpers --------------------------------------------------

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] random_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [COORD_BITS-1:0] to_coord(real v);
    if (v < 0.0) return '0;
    if (v > real'(COORD_MAX)) return COORD_BITS'(COORD_MAX);
    return COORD_BITS'(int'(v));
  endfunction

  // mostly points scattered across the band and its edges, the rest anywhere
  function automatic pixel_t random_pixel();
    pixel_t      p;
    int unsigned pick;
    real         cn, sn, nrm2, w, t, u;
    pick = $urandom_range(0, 99);
    p.rgb.red   = random_byte();
    p.rgb.green = random_byte();
    p.rgb.blue  = random_byte();
    cn = real'(int'(band.dir_cos)) / 16384.0;
    sn = real'(int'(band.dir_sin)) / 16384.0;
    nrm2 = cn * cn + sn * sn;
    if (pick < 70 && nrm2 > 1.0e-6) begin
      w = real'(band.sweep_width) / 16.0;
      t = real'(int'($urandom_range(0, 6000)) - 3000);
      u = w * (real'($urandom_range(0, 1400)) / 1000.0 - 0.7);
      p.x = to_coord(real'(band.center_x) / 16.0 - sn * t / $sqrt(nrm2) + cn * u / nrm2);
      p.y = to_coord(real'(band.center_y) / 16.0 + cn * t / $sqrt(nrm2) + sn * u / nrm2);
    end else if (pick < 90) begin
      p.x = COORD_BITS'($urandom_range(0, COORD_MAX));
      p.y = COORD_BITS'($urandom_range(0, COORD_MAX));
    end else begin
      p.x = $urandom_range(0, 1) ? COORD_BITS'(COORD_MAX) : '0;
      p.y = $urandom_range(0, 1) ? COORD_BITS'(COORD_MAX) : '0;
    end
    return p;
  endfunction

  task automatic add_pixel(int x, int y, int r, int g, int b);
    pixel_t p;
    p.x = COORD_BITS'(x);
    p.y = COORD_BITS'(y);
    p.rgb.red   = 8'(r);
    p.rgb.green = 8'(g);
    p.rgb.blue  = 8'(b);
    pixel_q.push_back(p);
  endtask

  task automatic queue_random_pixels(int unsigned n);
    repeat (n) pixel_q.push_back(random_pixel());
  endtask

  function automatic void pick_random_registers();
    real         ang;
    int unsigned w, wm, inv;
    reg_words[REG_CENTER_X] = ($urandom_range(0, 9) == 0) ?
                              16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 65520));
    reg_words[REG_CENTER_Y] = ($urandom_range(0, 9) == 0) ?
                              16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 65520));
    if ($urandom_range(0, 4) == 0) begin
      reg_words[REG_DIR_COS] = 16'($urandom_range(0, 65535));
      reg_words[REG_DIR_SIN] = 16'($urandom_range(0, 65535));
    end else begin
      ang = real'($urandom_range(0, 35999)) * PI / 18000.0;
      reg_words[REG_DIR_COS] = 16'(int'($cos(ang) * 16384.0));
      reg_words[REG_DIR_SIN] = 16'(int'($sin(ang) * 16384.0));
    end
    w = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 65535) : $urandom_range(160, 8000);
    reg_words[REG_SWEEP_WIDTH] = 16'(w);
    // reciprocal that matches the masked width, now and then a stray one
    wm = w & 32'h1FFF;
    inv = (wm == 0) ? 65535 : 2097152 / wm;
    if (inv > 65535) inv = 65535;
    reg_words[REG_INV_HALF_WIDTH] = ($urandom_range(0, 4) == 0) ?
                                    16'($urandom_range(0, 65535)) : 16'(inv);
    reg_words[REG_SWEEP_GAIN] = ($urandom_range(0, 6) == 0) ?
                                16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 512));
    reg_words[REG_EDGE_GAIN]  = ($urandom_range(0, 6) == 0) ?
                                16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 256));
  endfunction

  function automatic void set_registers(int cx, int cy, int dc, int ds,
                                        int w, int inv, int sg, int eg);
    reg_words[REG_CENTER_X]       = 16'(cx);
    reg_words[REG_CENTER_Y]       = 16'(cy);
    reg_words[REG_DIR_COS]        = 16'(dc);
    reg_words[REG_DIR_SIN]        = 16'(ds);
    reg_words[REG_SWEEP_WIDTH]    = 16'(w);
    reg_words[REG_INV_HALF_WIDTH] = 16'(inv);
    reg_words[REG_SWEEP_GAIN]     = 16'(sg);
    reg_words[REG_EDGE_GAIN]      = 16'(eg);
  endfunction

  // write all eight registers back to back; keep valid high throughout
  task automatic load_registers();
    cfg_idx_t idx;
    cfg_bus.valid <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_t'(i);
      cfg_bus.index <= idx;
      cfg_bus.data  <= reg_words[i];
      do @(posedge clk); while (!cfg_bus.ready);
      case (idx)
        REG_CENTER_X:       band.center_x       = reg_words[i];
        REG_CENTER_Y:       band.center_y       = reg_words[i];
        REG_DIR_COS:        band.dir_cos        = reg_words[i];
        REG_DIR_SIN:        band.dir_sin        = reg_words[i];
        REG_SWEEP_WIDTH:    band.sweep_width    = reg_words[i][WIDTH_W-1:0];
        REG_INV_HALF_WIDTH: band.inv_half_width = reg_words[i];
        REG_SWEEP_GAIN:     band.sweep_gain     = reg_words[i][SGAIN_W-1:0];
        REG_EDGE_GAIN:      band.edge_gain      = reg_words[i][EGAIN_W-1:0];
        default: ;
      endcase
    end
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_q.size() != 0 || pix_in_bus.valid || awaited_q.size() != 0);
  endtask

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  // ---- pixel driver ------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      pix_in_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (pix_in_bus.valid && pix_in_bus.ready) begin
        awaited_q.push_back('{pix: offered, rgb: brightened_rgb(offered, band)});
        accepted_count++;
      end
      if (!pix_in_bus.valid || pix_in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          pix_in_bus.valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          offered = pixel_q.pop_front();
          pix_in_bus.pixel_x  <= offered.x;
          pix_in_bus.pixel_y  <= offered.y;
          pix_in_bus.red_in   <= offered.rgb.red;
          pix_in_bus.green_in <= offered.rgb.green;
          pix_in_bus.blue_in  <= offered.rgb.blue;
          pix_in_bus.valid    <= 1'b1;
          send_gap = idle_gap();
        end else begin
          pix_in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---- result monitor ----------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      pix_out_bus.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (pix_out_bus.valid && pix_out_bus.ready) begin
        if (awaited_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d/%0d/%0d with nothing awaited",
                                  pix_out_bus.red_out, pix_out_bus.green_out,
                                  pix_out_bus.blue_out));
        end else begin
          awaited_t a;
          a = awaited_q.pop_front();
          if (pix_out_bus.red_out !== a.rgb.red)
            flag_mismatch($sformatf("pixel (%0d,%0d) red got %0d want %0d",
                                    a.pix.x, a.pix.y, pix_out_bus.red_out, a.rgb.red));
          if (pix_out_bus.green_out !== a.rgb.green)
            flag_mismatch($sformatf("pixel (%0d,%0d) green got %0d want %0d",
                                    a.pix.x, a.pix.y, pix_out_bus.green_out, a.rgb.green));
          if (pix_out_bus.blue_out !== a.rgb.blue)
            flag_mismatch($sformatf("pixel (%0d,%0d) blue got %0d want %0d",
                                    a.pix.x, a.pix.y, pix_out_bus.blue_out, a.rgb.blue));
        end
      end
      if (long_hold) begin
        pix_out_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pix_out_bus.ready <= 1'b0;
      end else begin
        pix_out_bus.ready <= 1'b1;
        recv_gap = idle_gap();
      end
    end
  end

  // hold the output off long enough for the pipeline to fill and stall
  initial begin
    long_hold = 1'b0;
    wait (accepted_count >= 100);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---- test sequence -----------------------------------------------------

  initial begin
    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    pix_in_bus.valid = 1'b0;
    pix_in_bus.pixel_x = '0;
    pix_in_bus.pixel_y = '0;
    pix_in_bus.red_in = '0;
    pix_in_bus.green_in = '0;
    pix_in_bus.blue_in = '0;
    pix_out_bus.ready = 1'b0;
    accepted_count = 0;
    mismatches = 0;
    idling_on = 1'b0;
    band.center_x       = CENTER_X_RST;
    band.center_y       = CENTER_Y_RST;
    band.dir_cos        = DIR_COS_RST;
    band.dir_sin        = DIR_SIN_RST;
    band.sweep_width    = SWEEP_WIDTH_RST;
    band.inv_half_width = INV_HALF_WIDTH_RST;
    band.sweep_gain     = SWEEP_GAIN_RST;
    band.edge_gain      = EDGE_GAIN_RST;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // defaults: band centre, frame corners, both band edges
    add_pixel(960, 540, 0, 0, 0);
    add_pixel(960, 540, 255, 255, 255);
    add_pixel(960, 540, 200, 100, 50);
    add_pixel(0, 0, 0, 0, 0);
    add_pixel(4095, 4095, 255, 255, 255);
    add_pixel(0, 4095, 255, 0, 170);
    add_pixel(4095, 0, 85, 255, 0);
    add_pixel(983, 527, 10, 250, 128);
    add_pixel(1003, 515, 40, 40, 40);
    add_pixel(1008, 512, 254, 1, 128);
    add_pixel(1012, 510, 90, 180, 240);
    add_pixel(917, 565, 0, 255, 7);
    wait_drained();

    // gains beyond their range and a reciprocal far too large for the width
    set_registers(15360, 8640, 16384, 0, 8000, 65535, 16'h03FF, 16'h01FF);
    load_registers();
    idling_on = 1'b1;
    add_pixel(960, 540, 0, 0, 0);
    add_pixel(960, 540, 255, 255, 255);
    add_pixel(961, 540, 10, 20, 30);
    add_pixel(959, 540, 100, 0, 200);
    add_pixel(1210, 540, 60, 60, 60);
    add_pixel(1215, 540, 3, 130, 250);
    add_pixel(1235, 540, 0, 0, 255);
    add_pixel(4095, 0, 128, 128, 128);
    wait_drained();

    pick_random_registers();
    load_registers();
    queue_random_pixels(500);
    wait_drained();

    // every register bit set, no idling
    idling_on = 1'b0;
    set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF, 16'hFFFF);
    load_registers();
    queue_random_pixels(100);
    wait_drained();

    idling_on = 1'b1;
    set_registers(0, 0, 0, 0, 0, 0, 0, 0);
    load_registers();
    queue_random_pixels(100);
    wait_drained();

    set_registers(0, 0, -16384, 16384, 160, 13107, 0, 256);
    load_registers();
    queue_random_pixels(100);
    wait_drained();

    set_registers(65535, 65535, 16384, -16384, 8000, 262, 512, 0);
    load_registers();
    queue_random_pixels(100);
    wait_drained();

    repeat (4) begin
      pick_random_registers();
      load_registers();
      queue_random_pixels(140);
      wait_drained();
    end

    // let any stray output show up before judging
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
